@@ hdl/vad_pkg.sv @@
// ----------------------------------------------------------------------------
// vad_pkg - shared definitions for the vibration alarm detector
// Register indexes, item modes, reset values and the queue word layout.
// ----------------------------------------------------------------------------
package vad_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int QUEUE_DEPTH   = 2;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOLD       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOTICE_COOLDOWN  = 2'd2;

	localparam logic [15:0] HOLD_RESET     = 16'd5000;
	localparam logic [15:0] COOLDOWN_RESET = 16'd10000;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	// word passed from front to back
	typedef struct packed {
		logic        mode;
		logic [31:0] now_ms;
		logic [31:0] sum_sq;
	} vad_entry_t;

	typedef struct packed {
		logic [15:0] change_threshold;
		logic [15:0] alarm_hold_ms;
		logic [15:0] notice_cooldown_ms;
	} vad_cfg_t;

endpackage

@@ hdl/vad_if.sv @@
// ----------------------------------------------------------------------------
// vad_if - channel interfaces of the vibration alarm detector
// Item input, result output and register write channels.
// ----------------------------------------------------------------------------
interface vad_item_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic        [31:0] now_ms;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;

	modport source (output valid, mode, now_ms, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, mode, now_ms, accel_x, accel_y, accel_z, output ready);
endinterface

interface vad_result_if;
	logic        valid;
	logic        ready;
	logic        alarm_active;
	logic        led_on;
	logic        alarm_began;
	logic        send_notice;
	logic [15:0] magnitude;
	logic [15:0] change;

	modport source (output valid, alarm_active, led_on, alarm_began, send_notice, magnitude,
		change, input ready);
	modport sink   (input valid, alarm_active, led_on, alarm_began, send_notice, magnitude,
		change, output ready);
endinterface

interface vad_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [vad_pkg::CFG_IDX_W-1:0] index;
	logic [15:0]                    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/vad_front.sv @@
// ----------------------------------------------------------------------------
// vad_front - item intake and sum of squares
// Takes one word, squares the three axes of a sample on a shared multiplier, queues it.
// ----------------------------------------------------------------------------
module vad_front (
	input  logic                clk,
	input  logic                arst_n,
	vad_item_if.sink            item,
	output logic                push_valid,
	input  logic                push_ready,
	output vad_pkg::vad_entry_t push_data
);

	typedef enum logic [1:0] {F_IDLE, F_SQ, F_PUSH} fstate_t;

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	fstate_t     state_q;
	logic [1:0]  axis_q;
	logic        mode_q;
	logic [31:0] now_q;
	logic [15:0] ax_q, ay_q, az_q;
	logic [31:0] sum_q;

	logic [15:0] sel;
	logic [15:0] abs_v;
	logic [31:0] square;

	always_comb begin
		case (axis_q)
			AXIS_X:  sel = ax_q;
			AXIS_Y:  sel = ay_q;
			default: sel = az_q;
		endcase
		// most negative code maps to 0x8000, which is its magnitude
		abs_v  = sel[15] ? (~sel + 16'd1) : sel;
		square = abs_v * abs_v;
	end

	assign item.ready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_data  = '{mode: mode_q, now_ms: now_q, sum_sq: sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			axis_q  <= AXIS_X;
		end else begin
			case (state_q)
				F_IDLE: begin
					axis_q <= AXIS_X;
					if (item.valid) begin
						state_q <= (item.mode == vad_pkg::MODE_TICK) ? F_PUSH : F_SQ;
					end
				end
				F_SQ: begin
					if (axis_q == AXIS_LAST) begin
						state_q <= F_PUSH;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && item.valid) begin
			mode_q <= item.mode;
			now_q  <= item.now_ms;
			ax_q   <= item.accel_x;
			ay_q   <= item.accel_y;
			az_q   <= item.accel_z;
			sum_q  <= '0;
		end else if (state_q == F_SQ) begin
			sum_q <= sum_q + square;
		end
	end

endmodule

@@ hdl/vad_fifo.sv @@
// ----------------------------------------------------------------------------
// vad_fifo - short queue between front and back
// Register based, one push and one pop per cycle; a push only while not full, a pop only while not empty.
// ----------------------------------------------------------------------------
module vad_fifo #(
	parameter int DEPTH = vad_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  vad_pkg::vad_entry_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output vad_pkg::vad_entry_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	vad_pkg::vad_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count above depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + CNT_W'($past(push)) - CNT_W'($past(pop)))
		else $error("queue count lost a push or pop");

endmodule

@@ hdl/vad_back.sv @@
// ----------------------------------------------------------------------------
// vad_back - root, change test and alarm state
// Bit-serial square root, then the alarm and LED update and result register.
// ----------------------------------------------------------------------------
module vad_back #(
	parameter int FRAC_BITS = vad_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vad_pkg::vad_cfg_t   cfg_regs,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  vad_pkg::vad_entry_t pop_data,
	vad_result_if.source        result
);

	typedef enum logic [1:0] {B_IDLE, B_ROOT, B_DONE} bstate_t;

	localparam int ROOT_STEPS = 16;
	localparam logic [3:0]  CNT_LAST  = 4'(ROOT_STEPS - 1);
	localparam logic [31:0] BIT_FIRST = 32'd1 << 30;
	localparam logic [16:0] PREV_RESET = 17'(1 << FRAC_BITS);

	bstate_t     state_q;
	logic [3:0]  cnt_q;
	logic [31:0] rem_q, root_q, bit_q;
	logic [31:0] now_q;

	logic [16:0] prev_mag_q;
	logic        alarm_q;
	logic [31:0] start_q;
	logic [31:0] last_notice_q;
	logic        led_q;

	logic        res_valid_q;
	logic        res_began_q, res_notice_q;
	logic [15:0] res_mag_q, res_chg_q;

	logic        slot_free;
	logic        res_load;
	logic [31:0] trial;
	logic        rem_ge;
	logic [16:0] mag17, diff17;
	logic        hit, notice_due, tick_held;

	assign slot_free = !res_valid_q || result.ready;
	assign trial     = root_q + bit_q;
	assign rem_ge    = rem_q >= trial;

	// a new result word enters the slot: tick on pop, sample on finish
	assign res_load = (state_q == B_IDLE && pop_valid && pop_ready &&
		pop_data.mode == vad_pkg::MODE_TICK) || (state_q == B_DONE && slot_free);

	always_comb begin
		mag17      = {1'b0, root_q[15:0]};
		diff17     = (mag17 >= prev_mag_q) ? mag17 - prev_mag_q : prev_mag_q - mag17;
		hit        = (diff17 > {1'b0, cfg_regs.change_threshold}) && !alarm_q;
		notice_due = (now_q - last_notice_q) > {16'd0, cfg_regs.notice_cooldown_ms};
		tick_held  = (pop_data.now_ms - start_q) < {16'd0, cfg_regs.alarm_hold_ms};
	end

	// a tick finishes on pop, so it also needs the result slot
	assign pop_ready = (state_q == B_IDLE) &&
		(pop_data.mode == vad_pkg::MODE_SAMPLE || slot_free);

	assign result.valid        = res_valid_q;
	assign result.alarm_active = alarm_q;
	assign result.led_on       = led_q;
	assign result.alarm_began  = res_began_q;
	assign result.send_notice  = res_notice_q;
	assign result.magnitude    = res_mag_q;
	assign result.change       = res_chg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			cnt_q         <= '0;
			prev_mag_q    <= PREV_RESET;
			alarm_q       <= 1'b0;
			start_q       <= '0;
			last_notice_q <= '0;
			led_q         <= 1'b0;
			res_valid_q   <= 1'b0;
			res_began_q   <= 1'b0;
			res_notice_q  <= 1'b0;
			res_mag_q     <= '0;
			res_chg_q     <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid && pop_ready) begin
						if (pop_data.mode == vad_pkg::MODE_SAMPLE) begin
							state_q <= B_ROOT;
							cnt_q   <= '0;
						end else begin
							// tick: blink while held, otherwise drop the alarm
							if (alarm_q && tick_held) begin
								led_q <= !led_q;
							end else begin
								alarm_q <= 1'b0;
								led_q   <= 1'b0;
							end
							res_began_q  <= 1'b0;
							res_notice_q <= 1'b0;
							res_mag_q    <= '0;
							res_chg_q    <= '0;
						end
					end
				end
				B_ROOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == CNT_LAST) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (slot_free) begin
						state_q    <= B_IDLE;
						prev_mag_q <= mag17;
						if (hit) begin
							alarm_q <= 1'b1;
							start_q <= now_q;
							if (notice_due) begin
								last_notice_q <= now_q;
							end
						end
						res_began_q  <= hit;
						res_notice_q <= hit && notice_due;
						res_mag_q    <= root_q[15:0];
						res_chg_q    <= diff17[15:0];
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// root datapath: one result bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid && pop_ready) begin
			rem_q  <= pop_data.sum_sq;
			root_q <= '0;
			bit_q  <= BIT_FIRST;
			now_q  <= pop_data.now_ms;
		end else if (state_q == B_ROOT) begin
			if (rem_ge) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	a_led_needs_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		led_q |-> alarm_q)
		else $error("LED lit with no alarm");

	a_notice_with_start: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_notice_q) |-> res_began_q)
		else $error("notice without a new alarm");

	a_began_sets_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_began_q) |-> (alarm_q && res_chg_q != 16'd0))
		else $error("alarm start without alarm state or change");

endmodule

@@ hdl/vibration_alarm_detector_top.sv @@
// ----------------------------------------------------------------------------
// vibration_alarm_detector_top - shock detector on acceleration magnitude
// A sample passes the front (squares on a shared multiplier), the queue, the
// bit-serial root and the decision; a tick skips the squares and the root.
// The bit-serial root sets the sample rate: the back end takes no new word
// until root and decision are done; front and back overlap via a 2-word queue.
// Reset (arst_n low) clears the queue, alarm, LED and stamps, sets the previous
// magnitude to one g and the registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module vibration_alarm_detector_top #(
	parameter int FRAC_BITS   = vad_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = vad_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	vad_item_if.sink     item,
	vad_result_if.source result,
	vad_cfg_if.sink      cfg
);

	// threshold default is a quarter g in the chosen Q format
	localparam logic [15:0] THR_RESET = 16'(1 << (FRAC_BITS - 2));

	vad_pkg::vad_cfg_t   cfg_q;
	vad_pkg::vad_entry_t push_data, pop_data;
	logic                push_valid, push_ready;
	logic                pop_valid, pop_ready;

	// Register writes: always ready, an unknown index is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.change_threshold   <= THR_RESET;
			cfg_q.alarm_hold_ms      <= vad_pkg::HOLD_RESET;
			cfg_q.notice_cooldown_ms <= vad_pkg::COOLDOWN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				vad_pkg::REG_CHANGE_THRESHOLD: cfg_q.change_threshold   <= cfg.data;
				vad_pkg::REG_ALARM_HOLD:       cfg_q.alarm_hold_ms      <= cfg.data;
				vad_pkg::REG_NOTICE_COOLDOWN:  cfg_q.notice_cooldown_ms <= cfg.data;
				default: ;
			endcase
		end
	end

	// Front: takes a word, squares and sums the axes (ticks go straight on).
	vad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Queue lets the front take the next word while the back runs a root.
	vad_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Back: root, change test, alarm/LED state, result register.
	vad_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

@@ bench/tb_vibration_alarm_detector_top.sv @@
// ----------------------------------------------------------------------------
// tb_vibration_alarm_detector_top - self-checking bench for the shock detector
// Drives samples and blink ticks through the item channel and compares every
// result word field by field against an in-bench model of the magnitude,
// change, alarm, LED and notice logic. Runs several register settings and
// sender/receiver idle mixes, with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_vibration_alarm_detector_top;

	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
	localparam int SETTLE_CYCLES  = 40;    // longer than a sample's latency
	localparam int HOLDOFF_CYCLES = 300;   // long receiver stall

	// index 3 decodes to no register; a write there must change nothing
	localparam logic [vad_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic               mode;
		logic        [31:0] now_ms;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} vib_word_t;

	typedef struct {
		logic        alarm_active;
		logic        led_on;
		logic        alarm_began;
		logic        send_notice;
		logic [15:0] magnitude;
		logic [15:0] change;
	} alarm_report_t;

	logic clk = 1'b0;
	logic arst_n;

	vad_item_if   item_ch();
	vad_result_if result_ch();
	vad_cfg_if    cfg_ch();

	vibration_alarm_detector_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Model state: mirrors the block after every accepted word.
	// Registers start at their reset values, previous magnitude at one g.
	// ------------------------------------------------------------------
	logic [15:0] thr_q  = 16'(1 << (vad_pkg::FRAC_BITS_DEF - 2));
	logic [15:0] hold_q = vad_pkg::HOLD_RESET;
	logic [15:0] cool_q = vad_pkg::COOLDOWN_RESET;

	logic [16:0] prev_mag  = 17'(1 << vad_pkg::FRAC_BITS_DEF);
	logic        alarm_on  = 1'b0;
	logic [31:0] alarm_t0  = '0;
	logic [31:0] notice_t  = '0;
	logic        led_lvl   = 1'b0;

	vib_word_t     pending_words[$];    // stimulus not yet offered
	alarm_report_t awaited_reports[$];  // predictions not yet matched
	vib_word_t     next_word;

	int words_offered  = 0;
	int words_taken    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_req    = 0;
	int holdoff_seen   = 0;
	int holdoff_left   = 0;
	int quiet_cycles   = 0;
	int error_count    = 0;
	logic [31:0] clock_ms;              // running time for well-formed traffic

	// floor square root, bit by bit from the top
	function automatic logic [15:0] floor_sqrt(input logic [31:0] v);
		logic [15:0] root;
		logic [15:0] trial;
		root = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (16'd1 << b);
			if (64'(trial) * 64'(trial) <= 64'(v))
				root = trial;
		end
		return root;
	endfunction

	// advances the model by one word and returns the report it should give
	function automatic alarm_report_t predict_report(input vib_word_t w);
		alarm_report_t r;
		int          sx, sy, sz;
		logic [31:0] energy;
		logic [16:0] mag;
		logic [16:0] delta;
		logic [31:0] elapsed;
		r = '{default: '0};
		if (w.mode == vad_pkg::MODE_SAMPLE) begin
			sx = w.ax;
			sy = w.ay;
			sz = w.az;
			if (sx < 0) sx = -sx;
			if (sy < 0) sy = -sy;
			if (sz < 0) sz = -sz;
			energy = 32'(sx * sx) + 32'(sy * sy) + 32'(sz * sz);
			mag    = {1'b0, floor_sqrt(energy)};
			delta  = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
			if (delta > {1'b0, thr_q} && !alarm_on) begin
				alarm_on      = 1'b1;
				alarm_t0      = w.now_ms;
				r.alarm_began = 1'b1;
				elapsed       = w.now_ms - notice_t;
				if (elapsed > {16'd0, cool_q}) begin
					r.send_notice = 1'b1;
					notice_t      = w.now_ms;
				end
			end
			prev_mag    = mag;
			r.magnitude = mag[15:0];
			r.change    = delta[15:0];
		end else begin
			// tick: blink while the hold lasts, then drop the alarm
			elapsed = w.now_ms - alarm_t0;
			if (alarm_on && elapsed < {16'd0, hold_q}) begin
				led_lvl = !led_lvl;
			end else begin
				alarm_on = 1'b0;
				led_lvl  = 1'b0;
			end
		end
		r.alarm_active = alarm_on;
		r.led_on       = led_lvl;
		return r;
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		$display("%0t ERROR: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Monitor: every handshake is sampled at the rising edge. Inputs move
	// only on falling edges, so nothing here races the drivers.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		alarm_report_t want;
		logic          moved;
		moved = 1'b0;

		if (cfg_ch.valid && cfg_ch.ready) begin
			moved = 1'b1;
			case (cfg_ch.index)
				vad_pkg::REG_CHANGE_THRESHOLD: thr_q = cfg_ch.data;
				vad_pkg::REG_ALARM_HOLD: hold_q = cfg_ch.data;
				vad_pkg::REG_NOTICE_COOLDOWN: cool_q = cfg_ch.data;
				default: ;
			endcase
		end

		if (item_ch.valid && item_ch.ready) begin
			moved = 1'b1;
			words_taken++;
			awaited_reports.push_back(predict_report('{item_ch.mode, item_ch.now_ms,
				item_ch.accel_x, item_ch.accel_y, item_ch.accel_z}));
		end

		if (result_ch.valid && result_ch.ready) begin
			moved = 1'b1;
			if (awaited_reports.size() == 0) begin
				report_error("result word with no prediction waiting");
			end else begin
				want = awaited_reports.pop_front();
				if (result_ch.alarm_active !== want.alarm_active)
					report_error($sformatf("alarm_active got %b want %b",
						result_ch.alarm_active, want.alarm_active));
				if (result_ch.led_on !== want.led_on)
					report_error($sformatf("led_on got %b want %b",
						result_ch.led_on, want.led_on));
				if (result_ch.alarm_began !== want.alarm_began)
					report_error($sformatf("alarm_began got %b want %b",
						result_ch.alarm_began, want.alarm_began));
				if (result_ch.send_notice !== want.send_notice)
					report_error($sformatf("send_notice got %b want %b",
						result_ch.send_notice, want.send_notice));
				if (result_ch.magnitude !== want.magnitude)
					report_error($sformatf("magnitude got %0d want %0d",
						result_ch.magnitude, want.magnitude));
				if (result_ch.change !== want.change)
					report_error($sformatf("change got %0d want %0d",
						result_ch.change, want.change));
			end
		end

		// watchdog: a long run of cycles without any handshake means a hang
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("vibration_alarm_detector_top verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Item driver: holds a word until taken, then offers the next one
	// unless the sender decides to idle this cycle.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!item_ch.valid || words_taken == words_offered) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				words_offered++;
				item_ch.valid   <= 1'b1;
				item_ch.mode    <= next_word.mode;
				item_ch.now_ms  <= next_word.now_ms;
				item_ch.accel_x <= next_word.ax;
				item_ch.accel_y <= next_word.ay;
				item_ch.accel_z <= next_word.az;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result ready: random stalls, plus a long hold-off on request so the
	// 2-word queue and pipeline fill and the input side backs up.
	always @(negedge clk) begin
		if (holdoff_req != holdoff_seen) begin
			holdoff_seen = holdoff_req;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_sample(input logic [31:0] t, input int x, input int y, input int z);
		pending_words.push_back('{vad_pkg::MODE_SAMPLE, t, 16'(x), 16'(y), 16'(z)});
	endtask

	task automatic push_tick(input logic [31:0] t);
		pending_words.push_back('{vad_pkg::MODE_TICK, t, 16'(0), 16'(0), 16'(0)});
	endtask

	function automatic int pick_axis(input bit shock);
		case ($urandom_range(7))
			0: return -32768;
			1: return 32767;
			default: return shock ? int'($signed(16'($urandom)))
				: $urandom_range(1600) - 800;
		endcase
	endfunction

	// Mostly plausible traffic: time moving forward, resting samples near
	// one g on z, occasional shocks, blink ticks. The rest is pure noise.
	task automatic queue_random_words(input int n);
		int roll;
		int gap_roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 15) begin
				pending_words.push_back('{1'($urandom), $urandom,
					16'($urandom), 16'($urandom), 16'($urandom)});
			end else begin
				gap_roll = $urandom_range(99);
				if (gap_roll < 50)      clock_ms += $urandom_range(40);
				else if (gap_roll < 80) clock_ms += $urandom_range(2000);
				else if (gap_roll < 95) clock_ms += $urandom_range(20000);
				else                    clock_ms += $urandom_range(131071);
				if (roll < 45)
					push_tick(clock_ms);
				else if (roll < 85)
					push_sample(clock_ms, $urandom_range(1600) - 800,
						$urandom_range(1600) - 800, 16384 + $urandom_range(3000) - 1500);
				else
					push_sample(clock_ms, pick_axis(1), pick_axis(1), pick_axis(1));
			end
		end
	endtask

	// block is idle: nothing queued, in flight or awaited, then settle time
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_words.size() != 0 || words_offered != words_taken
			|| awaited_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [vad_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk);
		while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// half the words, a pause until every result is back, then the rest
	task automatic run_phase(input int n, input int snd_idle, input int rcv_stall);
		send_idle_pct  = snd_idle;
		recv_stall_pct = rcv_stall;
		clock_ms = ($urandom_range(3) == 0) ? 32'hFFFF_0000 + $urandom_range(65535)
			: $urandom;
		queue_random_words(n / 2);
		wait_idle();
		queue_random_words(n - n / 2);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.mode      = vad_pkg::MODE_SAMPLE;
		item_ch.now_ms    = '0;
		item_ch.accel_x   = '0;
		item_ch.accel_y   = '0;
		item_ch.accel_z   = '0;
		result_ch.ready   = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = vad_pkg::REG_CHANGE_THRESHOLD;
		cfg_ch.data       = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values
		push_tick(32'd100);                          // tick, no alarm: LED low
		push_sample(32'd200, 0, 0, 16384);           // rest at one g, no change
		push_sample(32'd300, -32768, -32768, -32768); // max magnitude, alarm;
		                                              // no notice so soon after reset
		push_sample(32'd400, 32767, 32767, 32767);   // sample while alarming
		push_tick(32'd1000);                         // blink on
		push_tick(32'd2000);                         // blink off
		push_tick(32'd5300);                         // exactly at hold: clears
		push_sample(32'd20000, 0, 0, 0);             // alarm with notice
		push_tick(32'd24999);                        // last blink inside hold
		push_tick(32'd25000);                        // hold over
		push_sample(32'd25001, 0, 0, 16384);         // alarm, cooldown not passed
		push_tick(32'd30001);
		push_sample(32'hFFFF_FF00, 0, 0, 0);         // alarm just before wrap
		push_tick(32'h0000_0010);                    // elapsed across wrap, blinks
		push_tick(32'h0000_1400);                    // wrapped past hold, clears
		push_sample(32'h0000_2000, 32767, 0, 0);
		push_sample(32'h0000_2001, 0, -32768, 0);
		push_tick(32'hFFFF_FFFF);
		push_sample(32'hFFFF_FFFF, 0, 0, -32768);
		push_tick(32'h0000_0000);
		run_phase(380, 0, 0);

		// low extremes: zero threshold, zero hold, zero cooldown
		write_reg(vad_pkg::REG_CHANGE_THRESHOLD, 16'd0);
		write_reg(vad_pkg::REG_ALARM_HOLD, 16'd0);
		write_reg(vad_pkg::REG_NOTICE_COOLDOWN, 16'd0);
		write_reg(REG_SPARE, 16'hFFFF);
		push_tick(32'h8000_0000);                    // zero hold: any alarm drops
		push_sample(32'h8000_0001, 0, 0, 16384);
		push_sample(32'h8000_0002, 0, 0, 16384);     // change 0 is not above 0
		push_sample(32'h8000_0003, 0, 0, 16385);     // change 1 is above 0
		push_tick(32'h8000_0003);                    // zero hold clears at once
		run_phase(400, 81, 0);

		// high extremes: no change can reach the threshold
		write_reg(vad_pkg::REG_CHANGE_THRESHOLD, 16'hFFFF);
		write_reg(vad_pkg::REG_ALARM_HOLD, 16'hFFFF);
		write_reg(vad_pkg::REG_NOTICE_COOLDOWN, 16'hFFFF);
		run_phase(200, 0, 81);

		write_reg(vad_pkg::REG_CHANGE_THRESHOLD, 16'd1000);
		run_phase(400, 30, 30);

		// receiver holds off while the sender keeps pushing
		write_reg(vad_pkg::REG_CHANGE_THRESHOLD, 16'd4096);
		write_reg(vad_pkg::REG_ALARM_HOLD, 16'd5000);
		write_reg(vad_pkg::REG_NOTICE_COOLDOWN, 16'd10000);
		holdoff_req++;
		run_phase(300, 0, 0);

		write_reg(vad_pkg::REG_CHANGE_THRESHOLD, 16'($urandom_range(20000)));
		write_reg(vad_pkg::REG_ALARM_HOLD, 16'($urandom_range(8000)));
		write_reg(vad_pkg::REG_NOTICE_COOLDOWN, 16'($urandom_range(20000)));
		run_phase(300, 30, 30);

		if (error_count == 0)
			$display("vibration_alarm_detector_top verification clean");
		else
			$display("vibration_alarm_detector_top verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/vad_pkg.sv
hdl/vad_if.sv
hdl/vad_front.sv
hdl/vad_fifo.sv
hdl/vad_back.sv
hdl/vibration_alarm_detector_top.sv
bench/tb_vibration_alarm_detector_top.sv
